// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge except while reset is held.
`define MRP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mrp_pkg.sv =====
`timescale 1ns / 1ps

package mrp_pkg;

  typedef enum logic [2:0] {
    KIND_REALTIME = 3'd0,
    KIND_NOTE_ON  = 3'd1,
    KIND_NOTE_OFF = 3'd2,
    KIND_PITCH    = 3'd3,
    KIND_CONTROL  = 3'd4
  } event_kind_t;

  localparam logic [7:0] ST_NONE      = 8'h00;
  localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
  localparam logic [7:0] ST_NOTE_ON   = 8'h90;
  localparam logic [7:0] ST_CONTROL   = 8'hB0;
  localparam logic [7:0] ST_PROGRAM   = 8'hC0;
  localparam logic [7:0] ST_PITCH     = 8'hE0;
  localparam logic [7:0] ST_SYSTEM    = 8'hF0;
  localparam logic [7:0] ST_SONG_POS  = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
  localparam logic [7:0] ST_REALTIME  = 8'hF8;
  localparam logic [7:0] ST_HIGH_MASK = 8'hF0;

endpackage

// ===== rtl/midi_receive_parser.sv =====
`timescale 1ns / 1ps
// A result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output is taken; the single output
// register is the only buffer, so a stalled result holds off further input.
// Reset clears the running status, the pending flag, the held data byte and
// the output valid flag.
module midi_receive_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] first_value, [14:8] second_value, [15] zero
  output logic [2:0]  m_tuser    // [2:0] event_kind
);

  logic [7:0] running_status, running_status_next;
  logic       awaiting_second, awaiting_second_next;
  logic [6:0] held_first_data, held_first_data_next;

  logic                event_valid;
  mrp_pkg::event_kind_t event_kind;
  logic [7:0]          first_value;
  logic [6:0]          second_value;
  logic [7:0]          masked_status;

  logic                out_valid;
  mrp_pkg::event_kind_t out_kind;
  logic [7:0]          out_first;
  logic [6:0]          out_second;

  logic accept;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign masked_status = running_status & mrp_pkg::ST_HIGH_MASK;

  always_comb begin
    running_status_next  = running_status;
    awaiting_second_next = awaiting_second;
    held_first_data_next = held_first_data;
    event_valid  = 1'b0;
    event_kind   = mrp_pkg::KIND_REALTIME;
    first_value  = {1'b0, held_first_data};
    second_value = s_tdata[6:0];

    priority if (s_tdata[7]) begin
      if (s_tdata >= mrp_pkg::ST_REALTIME) begin
        // Real-time bytes pass straight through and leave the state alone.
        event_valid  = 1'b1;
        event_kind   = mrp_pkg::KIND_REALTIME;
        first_value  = s_tdata;
        second_value = 7'd0;
      end else begin
        running_status_next  = s_tdata;
        awaiting_second_next = 1'b0;
      end
    end else if (awaiting_second) begin
      // Second data byte: the channel nibble is dropped from the kept status.
      awaiting_second_next = 1'b0;
      running_status_next  = masked_status;
      if (masked_status == mrp_pkg::ST_NOTE_ON) begin
        event_valid = 1'b1;
        event_kind  = (s_tdata == 8'd0) ? mrp_pkg::KIND_NOTE_OFF : mrp_pkg::KIND_NOTE_ON;
      end else if (masked_status == mrp_pkg::ST_NOTE_OFF) begin
        event_valid = 1'b1;
        event_kind  = mrp_pkg::KIND_NOTE_OFF;
      end else if (masked_status == mrp_pkg::ST_PITCH) begin
        event_valid = 1'b1;
        event_kind  = mrp_pkg::KIND_PITCH;
      end else if (masked_status == mrp_pkg::ST_CONTROL) begin
        event_valid = 1'b1;
        event_kind  = mrp_pkg::KIND_CONTROL;
      end
    end else if (running_status == mrp_pkg::ST_NONE) begin
      // Data with no status in force is dropped.
    end else if (running_status < mrp_pkg::ST_PROGRAM) begin
      awaiting_second_next = 1'b1;
      held_first_data_next = s_tdata[6:0];
    end else if (running_status < mrp_pkg::ST_PITCH) begin
      held_first_data_next = s_tdata[6:0];
    end else if (running_status < mrp_pkg::ST_SYSTEM) begin
      awaiting_second_next = 1'b1;
      held_first_data_next = s_tdata[6:0];
    end else if (running_status == mrp_pkg::ST_SONG_POS) begin
      // The status is gone, so the second byte completes nothing.
      running_status_next  = mrp_pkg::ST_NONE;
      awaiting_second_next = 1'b1;
      held_first_data_next = s_tdata[6:0];
    end else if (running_status == mrp_pkg::ST_SONG_SEL) begin
      running_status_next  = mrp_pkg::ST_NONE;
      held_first_data_next = s_tdata[6:0];
    end else begin
      running_status_next = mrp_pkg::ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status  <= mrp_pkg::ST_NONE;
      awaiting_second <= 1'b0;
      held_first_data <= 7'd0;
    end else if (accept) begin
      running_status  <= running_status_next;
      awaiting_second <= awaiting_second_next;
      held_first_data <= held_first_data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_tready) begin
      out_valid <= accept && event_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && event_valid) begin
      out_kind   <= event_kind;
      out_first  <= first_value;
      out_second <= second_value;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_second, out_first};
  assign m_tuser  = out_kind;

endmodule

// ===== rtl/mrp_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mrp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser
);

  logic kind_realtime;

  assign kind_realtime = (m_tuser == mrp_pkg::KIND_REALTIME);

  // The output register is empty right after reset.
  `MRP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "output valid after reset")

  // A new result only follows an accepted input transaction.
  `MRP_ASSERT(a_result_has_cause, clk, rst, (m_tvalid && !$past(m_tvalid && !m_tready)) |-> $past(s_tvalid && s_tready), "result without an input transaction")

  // A real-time event carries a real-time byte and a zero second value.
  `MRP_ASSERT(a_realtime_payload, clk, rst, (m_tvalid && kind_realtime) |-> ((m_tdata[7:0] >= mrp_pkg::ST_REALTIME) && (m_tdata[15:8] == 8'd0)), "bad real-time payload")

  // Channel events carry data bytes only.
  `MRP_ASSERT(a_channel_payload, clk, rst, (m_tvalid && !kind_realtime) |-> ((m_tdata[7] == 1'b0) && (m_tdata[15] == 1'b0) && (m_tuser <= mrp_pkg::KIND_CONTROL)), "bad channel event payload")

  // A stalled result holds its payload.
  `MRP_ASSERT(a_stall_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

endmodule

bind midi_receive_parser mrp_checker u_mrp_checker (.*);
